// ----- sv/line_raster_framebuffer_assert.svh -----
// Assertion macros for the line raster framebuffer checker.
// Each macro needs clk in scope; all but the last also need rst_n.
`ifndef LINE_RASTER_FRAMEBUFFER_ASSERT_SVH
`define LINE_RASTER_FRAMEBUFFER_ASSERT_SVH

// Same-cycle implication, switched off while reset is asserted.
`define LRFB_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define LRFB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that stays active through reset.
`define LRFB_ASSERT_RST_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/lrfb_pkg.sv -----
// Shared constants, command codes and the queued command word of the line raster framebuffer.
// Used by the front end, the command queue, the back end, the top level and the checker.
`timescale 1ns / 1ps

package lrfb_pkg;

  // Framebuffer geometry.
  localparam int BUF_WIDTH  = 80;
  localparam int BUF_HEIGHT = 40;
  localparam int COL_W      = $clog2(BUF_WIDTH);
  localparam int ROW_W      = $clog2(BUF_HEIGHT);

  // Port field widths.
  localparam int OP_W    = 2;
  localparam int COORD_W = 12;
  localparam int RCOL_W  = 7;
  localparam int RROW_W  = 6;

  // Error term of the line walk, wide enough for the sum of both deltas.
  localparam int ERR_W = COORD_W + 2;

  // Command queue between the front end and the back end (power of two).
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Operation codes on the input port.
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_DRAW  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  // Command kinds after classification. A read outside the buffer and the
  // unused operation code both become a plain no-op that returns zero.
  typedef enum logic [1:0] {
    CMD_NOP   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_DRAW  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                  kind;
    logic signed [COORD_W-1:0]  x0;
    logic signed [COORD_W-1:0]  y0;
    logic signed [COORD_W-1:0]  x1;
    logic signed [COORD_W-1:0]  y1;
    logic [COORD_W-1:0]         dx;
    logic [COORD_W-1:0]         dy;
    logic                       sx_neg;
    logic                       sy_neg;
    logic [COL_W-1:0]           col;
    logic [ROW_W-1:0]           row;
  } cmd_t;

endpackage

// ----- sv/line_raster_framebuffer.sv -----
// Line raster framebuffer: a one-bit pixel buffer with clear, line draw and pixel read.
// Top level; instantiates lrfb_front, lrfb_fifo and lrfb_back, uses lrfb_pkg.
`timescale 1ns / 1ps

// The block holds a one-bit image of BUF_HEIGHT rows by BUF_WIDTH columns and
// takes one command word at a time: clear blanks every pixel, draw walks an
// all-octant Bresenham line from the start point to the end point and sets
// every visited pixel that lies on the buffer (both endpoints included,
// pixels off the buffer skipped), and read returns one stored pixel. Every
// accepted word yields exactly one result word, in order; its pixel value is
// the read pixel, and zero for clear, draw, an out-of-range read and the
// unused operation code. A front stage classifies each word and works out the
// line deltas, a four-entry queue decouples it from the back end, and the
// back end runs the commands against a row-organized memory, so new words
// keep being taken while a long line is still being drawn. In the back end
// a draw visits one pixel per cycle along the longer axis, a clear blanks
// one row per cycle, and a read goes through the registered memory read.
// After reset the block runs a clearing pass over all BUF_HEIGHT rows,
// during which in_stall stays high. The result register lets the back end
// finish a command while the previous result word still waits to be taken.

module line_raster_framebuffer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [lrfb_pkg::OP_W-1:0]           in_operation,
  input  logic signed [lrfb_pkg::COORD_W-1:0] in_start_x,
  input  logic signed [lrfb_pkg::COORD_W-1:0] in_start_y,
  input  logic signed [lrfb_pkg::COORD_W-1:0] in_end_x,
  input  logic signed [lrfb_pkg::COORD_W-1:0] in_end_y,
  input  logic [lrfb_pkg::RCOL_W-1:0]         in_read_column,
  input  logic [lrfb_pkg::RROW_W-1:0]         in_read_row,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_pixel_value
);
  import lrfb_pkg::*;

  // Queue handshake between the two halves.
  cmd_t q_wr_data, q_rd_data;
  logic q_push, q_full, q_pop, q_empty;

  // High while the post-reset clearing pass runs; holds off the input side.
  logic init_busy;

  lrfb_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_start_x     (in_start_x),
    .in_start_y     (in_start_y),
    .in_end_x       (in_end_x),
    .in_end_y       (in_end_y),
    .in_read_column (in_read_column),
    .in_read_row    (in_read_row),
    .init_busy      (init_busy),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_wr_data      (q_wr_data)
  );

  lrfb_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  // The back end owns the pixel memory and the result register.
  lrfb_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_rd_data       (q_rd_data),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .init_busy       (init_busy),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_value (out_pixel_value)
  );

endmodule

// ----- sv/lrfb_front.sv -----
// Front end: takes input words, classifies them and precomputes line deltas.
// Depends on lrfb_pkg; feeds lrfb_fifo.
`timescale 1ns / 1ps

module lrfb_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [lrfb_pkg::OP_W-1:0]          in_operation,
  input  logic signed [lrfb_pkg::COORD_W-1:0] in_start_x,
  input  logic signed [lrfb_pkg::COORD_W-1:0] in_start_y,
  input  logic signed [lrfb_pkg::COORD_W-1:0] in_end_x,
  input  logic signed [lrfb_pkg::COORD_W-1:0] in_end_y,
  input  logic [lrfb_pkg::RCOL_W-1:0]        in_read_column,
  input  logic [lrfb_pkg::RROW_W-1:0]        in_read_row,
  input  logic                               init_busy,
  input  logic                               q_full,
  output logic                               q_push,
  output lrfb_pkg::cmd_t                     q_wr_data
);
  import lrfb_pkg::*;

  logic                      fvalid_r, fvalid_nxt;
  cmd_t                      cmd_r, cmd_nxt;
  logic                      in_acc;
  logic signed [COORD_W:0]   diff_x, diff_y;
  logic [COORD_W:0]          abs_x, abs_y;

  assign q_push    = fvalid_r && !q_full;
  assign q_wr_data = cmd_r;
  assign in_stall  = init_busy || (fvalid_r && q_full);
  assign in_acc    = in_valid && !in_stall;

  assign diff_x = (COORD_W+1)'(in_end_x) - (COORD_W+1)'(in_start_x);
  assign diff_y = (COORD_W+1)'(in_end_y) - (COORD_W+1)'(in_start_y);
  assign abs_x  = diff_x[COORD_W] ? -diff_x : diff_x;
  assign abs_y  = diff_y[COORD_W] ? -diff_y : diff_y;

  always_comb begin
    cmd_nxt        = cmd_r;
    if (in_acc) begin
      cmd_nxt.x0     = in_start_x;
      cmd_nxt.y0     = in_start_y;
      cmd_nxt.x1     = in_end_x;
      cmd_nxt.y1     = in_end_y;
      cmd_nxt.dx     = abs_x[COORD_W-1:0];
      cmd_nxt.dy     = abs_y[COORD_W-1:0];
      cmd_nxt.sx_neg = !(in_start_x < in_end_x);
      cmd_nxt.sy_neg = !(in_start_y < in_end_y);
      cmd_nxt.col    = COL_W'(in_read_column);
      cmd_nxt.row    = ROW_W'(in_read_row);
      unique case (in_operation)
        OP_CLEAR: cmd_nxt.kind = CMD_CLEAR;
        OP_DRAW:  cmd_nxt.kind = CMD_DRAW;
        OP_READ: begin
          if ((32'(in_read_column) < BUF_WIDTH) && (32'(in_read_row) < BUF_HEIGHT)) begin
            cmd_nxt.kind = CMD_READ;
          end else begin
            cmd_nxt.kind = CMD_NOP;
          end
        end
        default:  cmd_nxt.kind = CMD_NOP;
      endcase
    end
  end

  always_comb begin
    if (in_acc) begin
      fvalid_nxt = 1'b1;
    end else if (q_push) begin
      fvalid_nxt = 1'b0;
    end else begin
      fvalid_nxt = fvalid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fvalid_r <= 1'b0;
    end else begin
      fvalid_r <= fvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

endmodule

// ----- sv/lrfb_fifo.sv -----
// Short command queue between the front end and the back end.
// Depends on lrfb_pkg for the command word and the queue depth.
`timescale 1ns / 1ps

module lrfb_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lrfb_pkg::cmd_t wr_data,
  output logic           full,
  input  logic           pop,
  output lrfb_pkg::cmd_t rd_data,
  output logic           empty
);
  import lrfb_pkg::*;

  localparam int CNT_W = QUEUE_AW + 1;

  cmd_t                q_mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;

  assign full    = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QUEUE_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QUEUE_AW'(1) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ----- sv/lrfb_back.sv -----
// Back end: executes queued commands against the row-organized pixel memory.
// Holds the clear sequencer, the line walker, the read path and the result register.
// Depends on lrfb_pkg; fed by lrfb_fifo.
`timescale 1ns / 1ps

module lrfb_back (
  input  logic           clk,
  input  logic           rst_n,
  input  lrfb_pkg::cmd_t q_rd_data,
  input  logic           q_empty,
  output logic           q_pop,
  output logic           init_busy,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           out_pixel_value
);
  import lrfb_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CLEAR = 6'b000010,
    ST_DRAW  = 6'b000100,
    ST_READ  = 6'b001000,
    ST_PICK  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  localparam logic [ROW_W-1:0]          LAST_ROW = ROW_W'(BUF_HEIGHT - 1);
  localparam logic signed [COORD_W-1:0] WIDTH_S  = COORD_W'(BUF_WIDTH);
  localparam logic signed [COORD_W-1:0] HEIGHT_S = COORD_W'(BUF_HEIGHT);

  state_t                     state_r, state_nxt;
  logic                       init_r, init_nxt;
  logic [ROW_W-1:0]           clr_row_r, clr_row_nxt;
  logic signed [COORD_W-1:0]  x_r, x_nxt, y_r, y_nxt, xe_r, xe_nxt, ye_r, ye_nxt;
  logic signed [ERR_W-1:0]    err_r, err_nxt, dx_r, dx_nxt, dyn_r, dyn_nxt;
  logic                       sx_neg_r, sx_neg_nxt, sy_neg_r, sy_neg_nxt;
  logic [ROW_W-1:0]           rd_row_r, rd_row_nxt;
  logic [COL_W-1:0]           col_r, col_nxt;
  logic                       pix_r, pix_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       out_pix_r, out_pix_nxt;
  logic [BUF_WIDTH-1:0]       rdata_r;
  logic [BUF_WIDTH-1:0]       pix_mem [BUF_HEIGHT];

  logic                       clr_we, set_we, out_load, out_free;
  logic                       on_buf, at_end, step_x, step_y;
  logic signed [ERR_W:0]      twice, dx_ext, dyn_ext;

  assign init_busy       = init_r;
  assign out_valid       = out_valid_r;
  assign out_pixel_value = out_pix_r;
  assign out_free        = !out_valid_r || !out_stall;

  // One Bresenham step: decisions on the doubled error term.
  assign twice   = {err_r, 1'b0};
  assign dx_ext  = (ERR_W+1)'(dx_r);
  assign dyn_ext = (ERR_W+1)'(dyn_r);
  assign step_x  = (twice >= dyn_ext);
  assign step_y  = (twice <= dx_ext);
  assign at_end  = (x_r == xe_r) && (y_r == ye_r);
  assign on_buf  = !x_r[COORD_W-1] && (x_r < WIDTH_S) &&
                   !y_r[COORD_W-1] && (y_r < HEIGHT_S);

  always_comb begin
    state_nxt   = state_r;
    init_nxt    = init_r;
    clr_row_nxt = clr_row_r;
    x_nxt       = x_r;
    y_nxt       = y_r;
    xe_nxt      = xe_r;
    ye_nxt      = ye_r;
    err_nxt     = err_r;
    dx_nxt      = dx_r;
    dyn_nxt     = dyn_r;
    sx_neg_nxt  = sx_neg_r;
    sy_neg_nxt  = sy_neg_r;
    rd_row_nxt  = rd_row_r;
    col_nxt     = col_r;
    pix_nxt     = pix_r;
    q_pop       = 1'b0;
    clr_we      = 1'b0;
    set_we      = 1'b0;
    out_load    = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          unique case (q_rd_data.kind)
            CMD_CLEAR: begin
              clr_row_nxt = '0;
              state_nxt   = ST_CLEAR;
            end
            CMD_DRAW: begin
              x_nxt      = q_rd_data.x0;
              y_nxt      = q_rd_data.y0;
              xe_nxt     = q_rd_data.x1;
              ye_nxt     = q_rd_data.y1;
              dx_nxt     = ERR_W'(q_rd_data.dx);
              dyn_nxt    = -ERR_W'(q_rd_data.dy);
              err_nxt    = ERR_W'(q_rd_data.dx) - ERR_W'(q_rd_data.dy);
              sx_neg_nxt = q_rd_data.sx_neg;
              sy_neg_nxt = q_rd_data.sy_neg;
              state_nxt  = ST_DRAW;
            end
            CMD_READ: begin
              rd_row_nxt = q_rd_data.row;
              col_nxt    = q_rd_data.col;
              state_nxt  = ST_READ;
            end
            default: begin
              pix_nxt   = 1'b0;
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_CLEAR: begin
        clr_we = 1'b1;
        if (clr_row_r == LAST_ROW) begin
          init_nxt  = 1'b0;
          pix_nxt   = 1'b0;
          state_nxt = init_r ? ST_IDLE : ST_DONE;
        end else begin
          clr_row_nxt = clr_row_r + ROW_W'(1);
        end
      end
      ST_DRAW: begin
        set_we = on_buf;
        if (at_end) begin
          pix_nxt   = 1'b0;
          state_nxt = ST_DONE;
        end else begin
          err_nxt = err_r + (step_x ? dyn_r : '0) + (step_y ? dx_r : '0);
          if (step_x) begin
            x_nxt = sx_neg_r ? x_r - COORD_W'(1) : x_r + COORD_W'(1);
          end
          if (step_y) begin
            y_nxt = sy_neg_r ? y_r - COORD_W'(1) : y_r + COORD_W'(1);
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_PICK;
      end
      ST_PICK: begin
        pix_nxt   = rdata_r[col_r];
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_load || (out_valid_r && out_stall);
    out_pix_nxt   = out_load ? pix_r : out_pix_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      init_r      <= 1'b1;
      clr_row_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_r      <= init_nxt;
      clr_row_r   <= clr_row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    xe_r     <= xe_nxt;
    ye_r     <= ye_nxt;
    err_r    <= err_nxt;
    dx_r     <= dx_nxt;
    dyn_r    <= dyn_nxt;
    sx_neg_r <= sx_neg_nxt;
    sy_neg_r <= sy_neg_nxt;
    rd_row_r <= rd_row_nxt;
    col_r    <= col_nxt;
    pix_r    <= pix_nxt;
    out_pix_r <= out_pix_nxt;
  end

  // Pixel memory: one row per entry, a whole-row clear or a single-bit set per cycle.
  always_ff @(posedge clk) begin
    if (clr_we) begin
      pix_mem[clr_row_r] <= '0;
    end else if (set_we) begin
      pix_mem[y_r[ROW_W-1:0]][x_r[COL_W-1:0]] <= 1'b1;
    end
    rdata_r <= pix_mem[rd_row_r];
  end

endmodule

// ----- sv/lrfb_checker.sv -----
// Port-level checker for the line raster framebuffer, bound to the top level.
// Depends on lrfb_pkg and line_raster_framebuffer_assert.svh.
`timescale 1ns / 1ps
`include "line_raster_framebuffer_assert.svh"

module lrfb_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_pixel_value
);
  import lrfb_pkg::*;

  // Words in flight: front stage, queue, back end and result register.
  localparam int MAX_OUTS = QUEUE_DEPTH + 3;
  localparam int OUTS_W   = $clog2(MAX_OUTS + 2);

  logic              in_acc, out_acc;
  logic [OUTS_W-1:0] outs_r, outs_nxt;

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign outs_nxt = outs_r + OUTS_W'(in_acc) - OUTS_W'(out_acc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outs_r <= '0;
    end else begin
      outs_r <= outs_nxt;
    end
  end

  `LRFB_ASSERT_RST_NEXT(a_reset_clear_stall, !rst_n, in_stall, "input not held off after reset")
  `LRFB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_pixel_value), "stalled result word changed")
  `LRFB_ASSERT(a_no_extra_result, out_valid, outs_r != '0, "result word without an accepted input word")
  `LRFB_ASSERT(a_bounded_inflight, 1'b1, outs_r <= OUTS_W'(MAX_OUTS), "more words in flight than storage allows")

endmodule

bind line_raster_framebuffer lrfb_checker u_lrfb_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_pixel_value (out_pixel_value)
);
